// ===== hdl/efg_pkg.sv =====
package efg_pkg;

	localparam int unsigned FLAG_WIDTH_DEF   = 32;
	localparam int unsigned WAITER_SLOTS_DEF = 8;

	// opcode field; the spare code 7 is a no-op answered with success
	typedef enum logic [2:0] {
		OP_INIT   = 3'd0,
		OP_TAKE   = 3'd1,
		OP_WAIT   = 3'd2,
		OP_GIVE   = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_KILL   = 3'd5,
		OP_CANCEL = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_UNSAT  = 2'd1,
		STS_STOP   = 2'd2,
		STS_QUEUED = 2'd3
	} sts_t;

	typedef enum logic {
		KIND_STATUS = 1'b0,
		KIND_WAKE   = 1'b1
	} kind_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic fin;
	} efg_cmd_t;

	typedef struct packed {
		logic       out_free;
		logic [2:0] op;
		logic       cancel_hit;
		logic       scan_hit;
		logic       scan_done;
	} efg_stat_t;

	// slot_id modulo the slot count by repeated subtraction (value < 8)
	function automatic logic [2:0] slot_wrap(input logic [2:0] v, input int unsigned n);
		logic [5:0] r;
		r = {3'b000, v};
		for (int k = 0; k < 8; k++) begin
			if ({26'd0, r} >= n) begin
				r = r - 6'(n);
			end
		end
		return r[2:0];
	endfunction

endpackage

// ===== hdl/efg_ctrl.sv =====
module efg_ctrl
	import efg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  efg_stat_t stat,
	output efg_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_SCAN = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					if (stat.op == OP_GIVE || stat.op == OP_KILL) begin
						state_d = S_SCAN;
					end else if (stat.op == OP_CANCEL && stat.cancel_hit) begin
						state_d = S_FIN;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_SCAN: begin
				// a slot that produces no notice steps on without the output
				if (!stat.scan_hit || stat.out_free) begin
					cmd.scan = 1'b1;
					if (stat.scan_done) begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/efg_dp.sv =====
module efg_dp
	import efg_pkg::*;
#(
	parameter int unsigned FLAG_WIDTH   = FLAG_WIDTH_DEF,
	parameter int unsigned WAITER_SLOTS = WAITER_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  efg_cmd_t              cmd,
	output efg_stat_t             stat,
	input  logic [2:0]            in_op,
	input  logic [FLAG_WIDTH-1:0] in_bits,
	input  logic                  in_all,
	input  logic                  in_ign,
	input  logic                  in_keep,
	input  logic [2:0]            in_slot,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic                  out_kind,
	output logic [1:0]            out_status,
	output logic [2:0]            out_slot,
	output logic [FLAG_WIDTH-1:0] out_value,
	output logic                  out_last
);

	localparam int unsigned SW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;

	// latched request
	logic [2:0]            op_q;
	logic [FLAG_WIDTH-1:0] bits_q;
	logic                  all_q, ign_q, keep_q;
	logic [SW-1:0]         slot_q;

	// group state
	logic [FLAG_WIDTH-1:0]   flag_q;
	logic [FLAG_WIDTH-1:0]   snap_q;
	logic [WAITER_SLOTS-1:0] valid_q;
	logic [FLAG_WIDTH-1:0]   miss_q [WAITER_SLOTS];
	logic [WAITER_SLOTS-1:0] allm_q;
	logic [WAITER_SLOTS-1:0] keepm_q;
	logic [SW-1:0]           idx_q;

	// output word register
	logic                  ovld_q;
	logic                  okind_q;
	logic [1:0]            osts_q;
	logic [2:0]            oslot_q;
	logic [FLAG_WIDTH-1:0] oval_q;
	logic                  olast_q;

	logic                  out_free;
	logic [FLAG_WIDTH-1:0] req_miss;
	logic                  req_ok;
	logic [FLAG_WIDTH-1:0] req_flag;
	logic [FLAG_WIDTH-1:0] cur_miss;
	logic [FLAG_WIDTH-1:0] new_miss;
	logic                  g_hit;
	logic                  g_wake;
	logic                  scan_hit;

	logic                  e_en;
	kind_t                 e_kind;
	sts_t                  e_sts;
	logic [2:0]            e_slot;
	logic [FLAG_WIDTH-1:0] e_val;
	logic                  e_last;

	assign out_free = !ovld_q || out_ready;

	assign req_miss = ign_q ? bits_q : (bits_q & ~flag_q);
	assign req_ok   = !((|req_miss) && (all_q || req_miss == bits_q));
	assign req_flag = keep_q ? flag_q : (flag_q & ~bits_q);

	assign cur_miss = miss_q[idx_q];
	assign new_miss = cur_miss & ~snap_q;
	assign g_hit    = valid_q[idx_q] && (|(cur_miss & snap_q));
	assign g_wake   = g_hit && (!(|new_miss) || !allm_q[idx_q]);
	assign scan_hit = (op_q == OP_GIVE) ? g_wake : valid_q[idx_q];

	assign stat.out_free   = out_free;
	assign stat.op         = op_q;
	assign stat.cancel_hit = valid_q[slot_q];
	assign stat.scan_hit   = scan_hit;
	assign stat.scan_done  = (idx_q == SW'(WAITER_SLOTS - 1));

	always_comb begin
		e_en   = 1'b0;
		e_kind = KIND_STATUS;
		e_sts  = STS_OK;
		e_slot = 3'd0;
		e_val  = '0;
		e_last = 1'b1;
		if (cmd.exec) begin
			case (op_q)
				OP_INIT: begin
					e_en = 1'b1;
				end
				OP_TAKE: begin
					e_en  = 1'b1;
					e_sts = req_ok ? STS_OK : STS_UNSAT;
				end
				OP_WAIT: begin
					e_en  = 1'b1;
					e_sts = req_ok ? STS_OK : STS_QUEUED;
				end
				OP_GIVE: begin
					e_en = 1'b0;
				end
				OP_CLEAR: begin
					e_en  = 1'b1;
					e_val = flag_q;
				end
				OP_KILL: begin
					e_en = 1'b0;
				end
				OP_CANCEL: begin
					e_en = 1'b1;
					if (valid_q[slot_q]) begin
						e_kind = KIND_WAKE;
						e_sts  = STS_UNSAT;
						e_slot = 3'(slot_q);
						e_last = 1'b0;
					end else begin
						e_sts = STS_UNSAT;
					end
				end
				default: begin
					e_en = 1'b1;
				end
			endcase
		end else if (cmd.scan) begin
			if (scan_hit) begin
				e_en   = 1'b1;
				e_kind = KIND_WAKE;
				e_sts  = (op_q == OP_GIVE) ? STS_OK : STS_STOP;
				e_slot = 3'(idx_q);
				e_last = 1'b0;
			end
		end else if (cmd.fin) begin
			e_en  = 1'b1;
			e_val = (op_q == OP_GIVE) ? flag_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_op;
			bits_q <= in_bits;
			all_q  <= in_all;
			ign_q  <= in_ign;
			keep_q <= in_keep;
			slot_q <= SW'(slot_wrap(in_slot, WAITER_SLOTS));
		end
		if (cmd.exec && op_q == OP_GIVE) begin
			snap_q <= flag_q | bits_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q  <= '0;
			valid_q <= '0;
			idx_q   <= '0;
		end else if (cmd.exec) begin
			idx_q <= '0;
			case (op_q)
				OP_INIT: begin
					flag_q  <= bits_q;
					valid_q <= '0;
				end
				OP_TAKE: begin
					flag_q <= req_flag;
				end
				OP_WAIT: begin
					flag_q <= req_flag;
					if (!req_ok) begin
						valid_q[slot_q] <= 1'b1;
					end
				end
				OP_GIVE: begin
					flag_q <= flag_q | bits_q;
				end
				OP_CLEAR: begin
					flag_q <= flag_q & ~bits_q;
				end
				OP_CANCEL: begin
					valid_q[slot_q] <= 1'b0;
				end
				default: begin
					flag_q <= flag_q;
				end
			endcase
		end else if (cmd.scan) begin
			idx_q <= idx_q + 1'b1;
			if (op_q == OP_GIVE) begin
				if (g_hit && !keepm_q[idx_q]) begin
					flag_q <= flag_q & ~cur_miss;
				end
				if (g_wake) begin
					valid_q[idx_q] <= 1'b0;
				end
			end else begin
				valid_q[idx_q] <= 1'b0;
			end
		end
	end

	// slot records: written by a failed wait, narrowed during a give scan
	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == OP_WAIT && !req_ok) begin
			miss_q[slot_q]  <= req_miss;
			allm_q[slot_q]  <= all_q;
			keepm_q[slot_q] <= keep_q;
		end else if (cmd.scan && op_q == OP_GIVE && g_hit) begin
			miss_q[idx_q] <= new_miss;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (e_en) begin
			ovld_q <= 1'b1;
		end else if (out_ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (e_en) begin
			okind_q <= e_kind;
			osts_q  <= e_sts;
			oslot_q <= e_slot;
			oval_q  <= e_val;
			olast_q <= e_last;
		end
	end

	assign out_valid  = ovld_q;
	assign out_kind   = okind_q;
	assign out_status = osts_q;
	assign out_slot   = oslot_q;
	assign out_value  = oval_q;
	assign out_last   = olast_q;

endmodule

// ===== hdl/event_flag_group.sv =====
// A request is latched when accepted and executed once the output register is free.
// Give and kill then step through the waiter slots one per cycle, holding on a slot
// whose wake notice waits for the output, and close with a status word.
// A cancel that frees a slot sends a wake notice and then its status word. No new item
// is accepted until the last one is through.
// Reset (arst_n low) clears the flag word, all slot valid bits and the output valid bit.
module event_flag_group
	import efg_pkg::*;
#(
	parameter int unsigned FLAG_WIDTH   = FLAG_WIDTH_DEF,
	parameter int unsigned WAITER_SLOTS = WAITER_SLOTS_DEF,
	localparam int unsigned IN_DW  = ((FLAG_WIDTH + 6 + 7) / 8) * 8,
	localparam int unsigned OUT_DW = ((FLAG_WIDTH + 5 + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// flag_bits, wait_all, ignore_current, keep_flags, slot_id[2:0], zero pad
	input  logic [IN_DW-1:0]  s_tdata,
	// opcode[2:0]
	input  logic [2:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// status[1:0], woken_slot[2:0], flag_value, zero pad
	output logic [OUT_DW-1:0] m_tdata,
	// kind
	output logic [0:0]        m_tuser,
	output logic              m_tlast
);

	efg_cmd_t              cmd;
	efg_stat_t             stat;
	logic                  o_kind;
	logic [1:0]            o_status;
	logic [2:0]            o_slot;
	logic [FLAG_WIDTH-1:0] o_value;

	efg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	efg_dp #(
		.FLAG_WIDTH   (FLAG_WIDTH),
		.WAITER_SLOTS (WAITER_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_op      (s_tuser),
		.in_bits    (s_tdata[FLAG_WIDTH-1:0]),
		.in_all     (s_tdata[FLAG_WIDTH]),
		.in_ign     (s_tdata[FLAG_WIDTH+1]),
		.in_keep    (s_tdata[FLAG_WIDTH+2]),
		.in_slot    (s_tdata[FLAG_WIDTH+5:FLAG_WIDTH+3]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_kind   (o_kind),
		.out_status (o_status),
		.out_slot   (o_slot),
		.out_value  (o_value),
		.out_last   (m_tlast)
	);

	assign m_tdata    = OUT_DW'({o_value, o_slot, o_status});
	assign m_tuser[0] = o_kind;

`ifndef SYNTHESIS
	// only the caller status closes an item; wake notices never do
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast != m_tuser[0]))
		else $error("last flag and word kind disagree");

	// one item at a time: no second word is taken right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in progress");

	a_wake_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (int'(m_tdata[4:2]) < WAITER_SLOTS))
		else $error("woken slot out of range");
`endif

endmodule
